>>> rtl/core/lfu_cache_lookup_replace_macros.svh
// ----------------------------------------------------------------------------
// LFU cache assertion macros
// Shared assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LFU_CACHE_LOOKUP_REPLACE_MACROS_SVH
`define LFU_CACHE_LOOKUP_REPLACE_MACROS_SVH
// implication under reset
`define LFU_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lfu check failed");
// next-cycle implication under reset
`define LFU_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lfu check failed");
`endif

>>> rtl/core/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU cache package
// Shared types and constants for the LFU cache.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
   localparam logic REQ_GET = 1'b0;
   localparam logic REQ_PUT = 1'b1;
   localparam int   CAP_BITS = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic load;    // capture request, start match
      logic update;  // apply table update
   } lfu_cmd_type;

   typedef struct packed {
      logic done;
   } lfu_sts_type;
endpackage
`default_nettype wire

>>> rtl/core/lfu_cache_lookup_replace.sv
// Result valid is raised after accept, once the match and update states have passed.
// A new request is accepted only in idle, so the next request waits for the
// table update of the previous one and for its response to be taken.
// Reset: synchronous, clears the cache to empty and capacity to 16.
// ----------------------------------------------------------------------------
// LFU cache top level
// Key-value cache with least-frequently-used replacement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_lookup_replace #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [4:0]  csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_type,
   input  wire logic [31:0] req_lookup_key,
   input  wire logic [31:0] req_write_value,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit,
   output logic [31:0]      rsp_read_value
);
   import lfu_pkg::*;

   lfu_cmd_type cmd;

   lfu_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd
   );

   lfu_dp #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
      .clock, .reset, .cmd, .csr_write_enable, .csr_write_data,
      .req_type, .req_lookup_key, .req_write_value, .rsp_hit, .rsp_read_value
   );
endmodule
`default_nettype wire

>>> rtl/core/lfu_ctrl.sv
// ----------------------------------------------------------------------------
// LFU cache controller
// Sequences match, victim select and update; owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output lfu_pkg::lfu_cmd_type    cmd
);
   import lfu_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_MATCH, S_UPDATE, S_RESP} state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_MATCH;
            end
            S_MATCH:  state_ff <= S_UPDATE;
            S_UPDATE: begin
               state_ff     <= S_RESP;
               rsp_valid_ff <= 1'b1;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = req_valid && (state_ff == S_IDLE);
   assign cmd.update = (state_ff == S_UPDATE);
endmodule
`default_nettype wire

>>> rtl/core/lfu_dp.sv
// ----------------------------------------------------------------------------
// LFU cache datapath
// Entry table, parallel key match, registered victim tree, table update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lfu_dp #(
   parameter int ENTRIES    = 16,
   parameter int COUNT_BITS = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lfu_pkg::lfu_cmd_type     cmd,
   input  wire logic                     csr_write_enable,
   input  wire logic [4:0]               csr_write_data,
   input  wire logic                     req_type,
   input  wire logic [31:0]              req_lookup_key,
   input  wire logic [31:0]              req_write_value,
   output logic                          rsp_hit,
   output logic [31:0]                   rsp_read_value
);
   import lfu_pkg::*;

   localparam int IB = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int OB = $clog2(ENTRIES + 1);
   localparam int TN = 1 << IB;
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   logic [CAP_BITS-1:0]   cap_ff;
   logic [ENTRIES-1:0]    valid_ff;
   logic [31:0]           key_ff   [ENTRIES];
   logic [31:0]           value_ff [ENTRIES];
   logic [COUNT_BITS-1:0] cnt_ff   [ENTRIES];
   logic [IB-1:0]         rank_ff  [ENTRIES];
   logic [OB-1:0]         occ_ff;

   logic                  put_ff;
   logic [31:0]           rkey_ff, rval_ff;
   logic                  hit_ff;
   logic [IB-1:0]         hidx_ff;
   logic                  vfound_ff;
   logic [IB-1:0]         vidx_ff;
   logic                  ffound_ff;
   logic [IB-1:0]         fidx_ff;
   logic                  hit_out_ff;
   logic [31:0]           rdata_ff;

   // match and free slot search
   logic                  hit_in;
   logic [IB-1:0]         hidx_in;
   logic                  ffound_in;
   logic [IB-1:0]         fidx_in;
   logic                  vfound_in;
   logic [IB-1:0]         vidx_in;

   always_comb begin
      hit_in = 1'b0; hidx_in = '0;
      ffound_in = 1'b0; fidx_in = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         if (!hit_in && valid_ff[j] && key_ff[j] == req_lookup_key) begin
            hit_in = 1'b1; hidx_in = IB'(j);
         end
         if (!ffound_in && !valid_ff[j]) begin
            ffound_in = 1'b1; fidx_in = IB'(j);
         end
      end
   end

   // victim tree: lowest count, then highest rank
   logic                  tv [2*TN];
   logic [COUNT_BITS-1:0] tc [2*TN];
   logic [IB-1:0]         tr [2*TN];
   logic [IB-1:0]         ti [2*TN];

   always_comb begin
      for (int n = 0; n < 2*TN; n++) begin
         tv[n] = 1'b0; tc[n] = '0; tr[n] = '0; ti[n] = '0;
      end
      for (int j = 0; j < ENTRIES; j++) begin
         tv[TN+j] = valid_ff[j];
         tc[TN+j] = cnt_ff[j];
         tr[TN+j] = rank_ff[j];
         ti[TN+j] = IB'(j);
      end
      for (int n = TN-1; n > 0; n--) begin
         if (tv[2*n+1] && (!tv[2*n] || tc[2*n+1] < tc[2*n] ||
             (tc[2*n+1] == tc[2*n] && tr[2*n+1] > tr[2*n]))) begin
            tv[n] = tv[2*n+1]; tc[n] = tc[2*n+1]; tr[n] = tr[2*n+1]; ti[n] = ti[2*n+1];
         end else begin
            tv[n] = tv[2*n]; tc[n] = tc[2*n]; tr[n] = tr[2*n]; ti[n] = ti[2*n];
         end
      end
      vfound_in = tv[1];
      vidx_in   = ti[1];
   end

   logic [CAP_BITS-1:0] ecap;
   always_comb begin
      ecap = (cap_ff == '0) ? CAP_BITS'(1) : cap_ff;
      if (32'(ecap) > ENTRIES) ecap = CAP_BITS'(ENTRIES);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         put_ff    <= req_type;
         rkey_ff   <= req_lookup_key;
         rval_ff   <= req_write_value;
         hit_ff    <= hit_in;
         hidx_ff   <= hidx_in;
         ffound_ff <= ffound_in;
         fidx_ff   <= fidx_in;
         vfound_ff <= vfound_in;
         vidx_ff   <= vidx_in;
      end
   end

   logic          evict;
   logic [IB-1:0] slot;
   logic          ins;
   always_comb begin
      evict = vfound_ff && ((32'(occ_ff) >= 32'(ecap)) || !ffound_ff);
      slot  = evict ? vidx_ff : fidx_ff;
      ins   = !hit_ff && (put_ff == REQ_PUT) && (evict || ffound_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= CAP_RESET;
         valid_ff <= '0;
         occ_ff   <= '0;
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (cmd.update) begin
            if (hit_ff) begin
               for (int j = 0; j < ENTRIES; j++)
                  if (IB'(j) != hidx_ff && valid_ff[j] && rank_ff[j] < rank_ff[hidx_ff])
                     rank_ff[j] <= rank_ff[j] + 1'b1;
               rank_ff[hidx_ff] <= '0;
               if (cnt_ff[hidx_ff] != CMAX) cnt_ff[hidx_ff] <= cnt_ff[hidx_ff] + 1'b1;
               if (put_ff == REQ_PUT) value_ff[hidx_ff] <= rval_ff;
            end else if (ins) begin
               for (int j = 0; j < ENTRIES; j++) begin
                  if (valid_ff[j] && IB'(j) != slot) begin
                     if (evict && rank_ff[j] > rank_ff[vidx_ff])
                        rank_ff[j] <= rank_ff[j];
                     else
                        rank_ff[j] <= rank_ff[j] + 1'b1;
                  end
               end
               valid_ff[slot] <= 1'b1;
               key_ff[slot]   <= rkey_ff;
               value_ff[slot] <= rval_ff;
               cnt_ff[slot]   <= COUNT_BITS'(1);
               rank_ff[slot]  <= '0;
               if (!evict) occ_ff <= occ_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         hit_out_ff <= hit_ff;
         rdata_ff   <= (hit_ff && put_ff == REQ_GET) ? value_ff[hidx_ff] : 32'd0;
      end
   end

   assign rsp_hit        = hit_out_ff;
   assign rsp_read_value = rdata_ff;
endmodule
`default_nettype wire

>>> rtl/core/lfu_checker.sv
// ----------------------------------------------------------------------------
// LFU cache port checker
// Port-level checks on word flow, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lfu_cache_lookup_replace_macros.svh"
module lfu_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit,
   input wire logic [31:0] rsp_read_value
);
   `LFU_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_valid, !req_ready)
   `LFU_ASSERT_NEXT(a_accept_blocks, clock, reset, req_valid && req_ready, !req_ready)
   `LFU_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, ##1 (rsp_valid && $stable(rsp_read_value)))
   `LFU_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, rsp_read_value == 32'd0)
endmodule
bind lfu_cache_lookup_replace lfu_checker u_checker (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_hit, .rsp_read_value
);
`default_nettype wire

>>> tb/sv/lfu_cache_lookup_replace_test.sv
// ----------------------------------------------------------------------------
// LFU cache lookup/replace testbench
// Drives get/put words with bursty valid and random response stalls, predicts
// hit and read value with a behavioral LFU table, and compares each response
// word in order. Capacity is changed between phases while the cache is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lfu_cache_lookup_replace_test;
   import lfu_pkg::*;

   localparam int SLOTS     = 16;
   localparam int COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic        kind;
      logic [31:0] key;
      logic [31:0] value;
   } req_word_type;

   typedef struct packed {
      logic        hit;
      logic [31:0] value;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [4:0]  csr_write_data;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [31:0] req_lookup_key;
   logic [31:0] req_write_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_hit;
   logic [31:0] rsp_read_value;

   lfu_cache_lookup_replace dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_lookup_key  (req_lookup_key),
      .req_write_value (req_write_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_read_value  (rsp_read_value)
   );

   // shadow LFU table
   logic        tbl_valid [SLOTS];
   logic [31:0] tbl_key   [SLOTS];
   logic [31:0] tbl_value [SLOTS];
   int unsigned tbl_uses  [SLOTS];
   int unsigned tbl_rank  [SLOTS];
   int unsigned tbl_fill;
   logic [4:0]  cap_reg;

   req_word_type pending_reqs[$];
   rsp_word_type expected_rsps[$];
   logic [31:0] key_pool[$];
   int  errors;
   int  burst_left, gap_left;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic void table_clear();
      for (int j = 0; j < SLOTS; j++) begin
         tbl_valid[j] = 1'b0;
         tbl_uses[j]  = 0;
         tbl_rank[j]  = 0;
      end
      tbl_fill = 0;
   endfunction

   function automatic void mark_used(int s);
      int unsigned prev;
      prev = tbl_rank[s];
      for (int j = 0; j < SLOTS; j++)
         if (j != s && tbl_valid[j] && tbl_rank[j] < prev) tbl_rank[j]++;
      tbl_rank[s] = 0;
      if (tbl_uses[s] < COUNT_MAX) tbl_uses[s]++;
   endfunction

   function automatic int evict_lfu();
      int v;
      v = -1;
      for (int j = 0; j < SLOTS; j++) begin
         if (!tbl_valid[j]) continue;
         if (v < 0 || tbl_uses[j] < tbl_uses[v] ||
             (tbl_uses[j] == tbl_uses[v] && tbl_rank[j] > tbl_rank[v]))
            v = j;
      end
      if (v < 0) return -1;
      for (int j = 0; j < SLOTS; j++)
         if (j != v && tbl_valid[j] && tbl_rank[j] > tbl_rank[v]) tbl_rank[j]--;
      tbl_valid[v] = 1'b0;
      if (tbl_fill > 0) tbl_fill--;
      return v;
   endfunction

   function automatic rsp_word_type lfu_lookup(req_word_type w);
      rsp_word_type r;
      int           found, slot;
      int unsigned  cap;
      found = -1;
      slot  = -1;
      r     = '0;
      for (int j = 0; j < SLOTS; j++)
         if (found < 0 && tbl_valid[j] && tbl_key[j] == w.key) found = j;
      if (found >= 0) begin
         r.hit = 1'b1;
         if (w.kind == REQ_PUT) tbl_value[found] = w.value;
         else r.value = tbl_value[found];
         mark_used(found);
         return r;
      end
      if (w.kind == REQ_GET) return r;
      cap = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
      if (tbl_fill >= cap) slot = evict_lfu();
      if (slot < 0)
         for (int j = 0; j < SLOTS; j++)
            if (slot < 0 && !tbl_valid[j]) slot = j;
      if (slot < 0) slot = evict_lfu();
      for (int j = 0; j < SLOTS; j++)
         if (tbl_valid[j]) tbl_rank[j]++;
      tbl_valid[slot] = 1'b1;
      tbl_key[slot]   = w.key;
      tbl_value[slot] = w.value;
      tbl_uses[slot]  = 1;
      tbl_rank[slot]  = 0;
      tbl_fill++;
      return r;
   endfunction

   // driver: bursts and gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid  <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) expected_rsps.push_back(lfu_lookup(pending_reqs.pop_front()));
         if (pending_reqs.size() > 0 && gap_left == 0) begin
            req_valid       <= 1'b1;
            req_type        <= pending_reqs[0].kind;
            req_lookup_key  <= pending_reqs[0].key;
            req_write_value <= pending_reqs[0].value;
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) gap_left <= gap_left - 1;
         end
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response word hit=%0b value=%h",
                        $time, rsp_hit, rsp_read_value);
               errors++;
            end else begin
               rsp_word_type e;
               e = expected_rsps.pop_front();
               if (rsp_hit !== e.hit) begin
                  $display("%0t: hit expected %0b actual %0b", $time, e.hit, rsp_hit);
                  errors++;
               end
               if (rsp_read_value !== e.value) begin
                  $display("%0t: read_value expected %h actual %h",
                           $time, e.value, rsp_read_value);
                  errors++;
               end
            end
         end
         case ($urandom_range(0, 9))
            0, 1, 2: rsp_ready <= 1'b0;
            default: rsp_ready <= 1'b1;
         endcase
      end
   end

   task automatic push_req(logic kind, logic [31:0] key, logic [31:0] value);
      req_word_type w;
      w.kind  = kind;
      w.key   = key;
      w.value = value;
      pending_reqs.push_back(w);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] cap);
      csr_write_enable <= 1'b1;
      csr_write_data   <= cap;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cap_reg = cap;
   endtask

   function automatic logic [31:0] pick_key();
      logic [31:0] k;
      if (key_pool.size() > 0 && $urandom_range(0, 4) != 0)
         return key_pool[$urandom_range(0, key_pool.size() - 1)];
      k = $urandom();
      key_pool.push_back(k);
      if (key_pool.size() > 24) void'(key_pool.pop_front());
      return k;
   endfunction

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++)
         push_req(1'($urandom_range(0, 1)), pick_key(), $urandom());
   endtask

   initial begin
      logic [4:0] caps[6];
      clock            = 1'b0;
      errors           = 0;
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_type         = REQ_GET;
      req_lookup_key   = '0;
      req_write_value  = '0;
      rsp_ready        = 1'b0;
      burst_left       = 0;
      gap_left         = 0;
      cap_reg          = CAP_RESET;
      table_clear();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty miss, extremes, update, LFU tie break, eviction
      push_req(REQ_GET, 32'h0, 32'h0);
      push_req(REQ_PUT, 32'h0, 32'hFFFF_FFFF);
      push_req(REQ_PUT, 32'hFFFF_FFFF, 32'h0);
      push_req(REQ_GET, 32'h0, 32'h1234_5678);
      push_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
      push_req(REQ_PUT, 32'h0, 32'hA5A5_5A5A);
      push_req(REQ_GET, 32'h0, 32'h0);
      for (int i = 1; i <= 16; i++) push_req(REQ_PUT, 32'h100 + i, i);
      push_req(REQ_GET, 32'h101, 32'h0);
      push_req(REQ_GET, 32'hFFFF_FFFF, 32'h0);
      drain();

      // capacity 0 acts as one entry, capacity above the table acts as 16,
      // and lowering below occupancy keeps occupancy
      caps = '{5'd0, 5'd31, 5'd3, 5'd1, 5'd16, 5'd7};
      foreach (caps[c]) begin
         write_capacity(caps[c]);
         random_phase(90);
         drain();
      end

      // hot key stays resident while cold keys replace each other
      write_capacity(5'd2);
      push_req(REQ_PUT, 32'hCAFE_0001, 32'h1);
      for (int i = 0; i < 20; i++) push_req(REQ_GET, 32'hCAFE_0001, 32'h0);
      push_req(REQ_PUT, 32'hCAFE_0002, 32'h2);
      push_req(REQ_PUT, 32'hCAFE_0003, 32'h3);
      push_req(REQ_GET, 32'hCAFE_0001, 32'h0);
      push_req(REQ_GET, 32'hCAFE_0002, 32'h0);
      drain();

      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end
endmodule
